[rtl/teq_pkg.sv]
package teq_pkg;

  // Table geometry
  localparam int unsigned DEPTH  = 32;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W  = CNT_W + 1;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned ID_W   = 8;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [SUM_W-1:0]  sum_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_ADDED = 3'd0,
    ST_DUP   = 3'd1,
    ST_FULL  = 3'd2,
    ST_FIRE  = 3'd3,
    ST_NONE  = 3'd4
  } status_e;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_RD,
    S_ADD_CHK,
    S_ADD_DEC,
    S_SH_RD,
    S_SH_WR,
    S_INS,
    S_TK_RD,
    S_TK_DEC,
    S_TK_END
  } state_e;

  // Read address select: current index or the one below it
  typedef enum logic {
    RD_CUR,
    RD_PREV
  } rd_sel_e;

  typedef struct packed {
    logic [TIME_W-1:0] evt_time;
    logic [ID_W-1:0]   slat;
    logic [ID_W-1:0]   cue;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic    load_req;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    scan_chk;
    logic    shift_wr;
    logic    ins_wr;
    logic    pop;
    logic    emit;
    status_e emit_st;
    logic    emit_last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_tick;
    logic cnt_zero;
    logic full;
    logic idx_end;
    logic idx_at_pos;
    logic dup;
    logic due;
    logic pend_v;
    logic out_free;
  } sts_t;

  // Logical slot to physical address in the circular table
  function automatic addr_t phys_addr(addr_t head, cnt_t lidx);
    sum_t sum;
    sum = sum_t'(head) + sum_t'(lidx);
    if (sum >= sum_t'(DEPTH)) begin
      sum = sum - sum_t'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

[rtl/teq_if.sv]
// Request channel
interface teq_in_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [teq_pkg::TIME_W-1:0]  event_time;
  logic [teq_pkg::ID_W-1:0]    slat_id;
  logic [teq_pkg::ID_W-1:0]    cue_id;

  modport source (output valid, req_type, event_time, slat_id, cue_id, input ready);
  modport sink   (input valid, req_type, event_time, slat_id, cue_id, output ready);
endinterface

// Result channel
interface teq_out_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  status;
  logic [teq_pkg::ID_W-1:0]    fire_slat;
  logic [teq_pkg::ID_W-1:0]    fire_cue;
  logic [teq_pkg::TIME_W-1:0]  fire_time;
  logic                        last_of_run;

  modport source (output valid, status, fire_slat, fire_cue, fire_time, last_of_run,
                  input ready);
  modport sink   (input valid, status, fire_slat, fire_cue, fire_time, last_of_run,
                  output ready);
endinterface

[rtl/teq_datapath.sv]
module teq_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  teq_pkg::cmd_t              cmd_i,
  output teq_pkg::sts_t              sts_o,
  input  logic                       req_type_i,
  input  logic [teq_pkg::TIME_W-1:0] event_time_i,
  input  logic [teq_pkg::ID_W-1:0]   slat_id_i,
  input  logic [teq_pkg::ID_W-1:0]   cue_id_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [2:0]                 status_o,
  output logic [teq_pkg::ID_W-1:0]   fire_slat_o,
  output logic [teq_pkg::ID_W-1:0]   fire_cue_o,
  output logic [teq_pkg::TIME_W-1:0] fire_time_o,
  output logic                       last_o
);

  // Event table, circular, sorted from head
  teq_pkg::entry_t mem_q [teq_pkg::DEPTH];

  teq_pkg::addr_t  head_q;
  teq_pkg::cnt_t   count_q;
  teq_pkg::cnt_t   idx_q;
  teq_pkg::cnt_t   pos_q;
  logic            found_q;
  logic            dup_q;
  teq_pkg::entry_t req_q;
  teq_pkg::entry_t rd_q;
  teq_pkg::entry_t pend_q;
  logic            pend_v_q;

  logic                       out_valid_q;
  teq_pkg::status_e           out_st_q;
  logic [teq_pkg::ID_W-1:0]   out_slat_q;
  logic [teq_pkg::ID_W-1:0]   out_cue_q;
  logic [teq_pkg::TIME_W-1:0] out_time_q;
  logic                       out_last_q;

  teq_pkg::cnt_t   ins_pos;
  teq_pkg::cnt_t   rd_lidx;
  teq_pkg::addr_t  rd_addr;
  teq_pkg::addr_t  wr_addr;
  teq_pkg::entry_t wr_data;
  logic            wr_en;
  logic            out_free;

  assign ins_pos  = found_q ? pos_q : count_q;
  assign out_free = !out_valid_q || out_ready_i;

  // Table addressing
  assign rd_lidx = (cmd_i.rd_sel == teq_pkg::RD_PREV) ? idx_q - teq_pkg::cnt_t'(1) : idx_q;
  assign rd_addr = teq_pkg::phys_addr(head_q, rd_lidx);
  assign wr_en   = cmd_i.shift_wr || cmd_i.ins_wr;
  assign wr_addr = cmd_i.shift_wr ? teq_pkg::phys_addr(head_q, idx_q)
                                  : teq_pkg::phys_addr(head_q, ins_pos);
  assign wr_data = cmd_i.shift_wr ? rd_q : req_q;

  // Table memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q.evt_time <= event_time_i;
      req_q.slat     <= slat_id_i;
      req_q.cue      <= cue_id_i;
    end
  end

  // Scan, shift and pop bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      count_q  <= '0;
      idx_q    <= '0;
      pos_q    <= '0;
      found_q  <= 1'b0;
      dup_q    <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      if (cmd_i.load_req) begin
        idx_q    <= '0;
        found_q  <= 1'b0;
        dup_q    <= 1'b0;
        pend_v_q <= 1'b0;
      end
      if (cmd_i.scan_chk) begin
        idx_q <= idx_q + teq_pkg::cnt_t'(1);
        if (rd_q.slat == req_q.slat && rd_q.cue == req_q.cue) begin
          dup_q <= 1'b1;
        end
        if (!found_q && req_q.evt_time < rd_q.evt_time) begin
          found_q <= 1'b1;
          pos_q   <= idx_q;
        end
      end
      if (cmd_i.shift_wr) begin
        idx_q <= idx_q - teq_pkg::cnt_t'(1);
      end
      if (cmd_i.ins_wr) begin
        count_q <= count_q + teq_pkg::cnt_t'(1);
      end
      if (cmd_i.pop) begin
        head_q   <= teq_pkg::phys_addr(head_q, teq_pkg::cnt_t'(1));
        count_q  <= count_q - teq_pkg::cnt_t'(1);
        pend_v_q <= 1'b1;
      end else if (cmd_i.emit && cmd_i.emit_st == teq_pkg::ST_FIRE) begin
        pend_v_q <= 1'b0;
      end
    end
  end

  // Popped entry waiting for its result slot
  always_ff @(posedge clk_i) begin
    if (cmd_i.pop) begin
      pend_q <= rd_q;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_st_q   <= cmd_i.emit_st;
      out_last_q <= cmd_i.emit_last;
      if (cmd_i.emit_st == teq_pkg::ST_FIRE) begin
        out_slat_q <= pend_q.slat;
        out_cue_q  <= pend_q.cue;
        out_time_q <= pend_q.evt_time;
      end else begin
        out_slat_q <= '0;
        out_cue_q  <= '0;
        out_time_q <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_st_q;
  assign fire_slat_o = out_slat_q;
  assign fire_cue_o  = out_cue_q;
  assign fire_time_o = out_time_q;
  assign last_o      = out_last_q;

  // Status to controller
  always_comb begin
    sts_o.is_tick    = req_type_i;
    sts_o.cnt_zero   = (count_q == '0);
    sts_o.full       = (count_q == teq_pkg::cnt_t'(teq_pkg::DEPTH));
    sts_o.idx_end    = (idx_q == count_q);
    sts_o.idx_at_pos = (idx_q == ins_pos);
    sts_o.dup        = dup_q;
    sts_o.due        = (req_q.evt_time >= rd_q.evt_time);
    sts_o.pend_v     = pend_v_q;
    sts_o.out_free   = out_free;
  end

  // Checks
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("result issued while output register busy");

  a_ins_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ins_wr |-> (count_q != teq_pkg::cnt_t'(teq_pkg::DEPTH)) && !dup_q)
    else $error("insert into full table or of duplicate");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> (count_q != '0))
    else $error("pop from empty table");

  a_fire_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && cmd_i.emit_st == teq_pkg::ST_FIRE) |-> pend_v_q)
    else $error("fire result without pending entry");

  a_fire_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && cmd_i.emit_st == teq_pkg::ST_FIRE) |=>
      (out_valid_q && out_st_q == teq_pkg::ST_FIRE))
    else $error("fire result not presented");

endmodule

[rtl/teq_ctrl.sv]
module teq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  teq_pkg::sts_t sts_i,
  output teq_pkg::cmd_t cmd_o
);

  teq_pkg::state_e state_q;
  teq_pkg::state_e state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= teq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      teq_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d = sts_i.is_tick ? teq_pkg::S_TK_RD : teq_pkg::S_ADD_RD;
        end
      end
      // duplicate check and insert position: read, then compare, each entry in turn
      teq_pkg::S_ADD_RD: begin
        if (sts_i.idx_end) begin
          state_d = teq_pkg::S_ADD_DEC;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = teq_pkg::RD_CUR;
          state_d      = teq_pkg::S_ADD_CHK;
        end
      end
      teq_pkg::S_ADD_CHK: begin
        cmd_o.scan_chk = 1'b1;
        state_d        = teq_pkg::S_ADD_RD;
      end
      teq_pkg::S_ADD_DEC: begin
        if (sts_i.dup || sts_i.full) begin
          if (sts_i.out_free) begin
            cmd_o.emit      = 1'b1;
            cmd_o.emit_st   = sts_i.dup ? teq_pkg::ST_DUP : teq_pkg::ST_FULL;
            cmd_o.emit_last = 1'b1;
            state_d         = teq_pkg::S_IDLE;
          end
        end else begin
          state_d = teq_pkg::S_SH_RD;
        end
      end
      // open a slot: move entries up from the tail
      teq_pkg::S_SH_RD: begin
        if (sts_i.idx_at_pos) begin
          state_d = teq_pkg::S_INS;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = teq_pkg::RD_PREV;
          state_d      = teq_pkg::S_SH_WR;
        end
      end
      teq_pkg::S_SH_WR: begin
        cmd_o.shift_wr = 1'b1;
        state_d        = teq_pkg::S_SH_RD;
      end
      teq_pkg::S_INS: begin
        if (sts_i.out_free) begin
          cmd_o.ins_wr    = 1'b1;
          cmd_o.emit      = 1'b1;
          cmd_o.emit_st   = teq_pkg::ST_ADDED;
          cmd_o.emit_last = 1'b1;
          state_d         = teq_pkg::S_IDLE;
        end
      end
      // tick: look at head, keep one popped entry pending to know the last one
      teq_pkg::S_TK_RD: begin
        if (sts_i.cnt_zero) begin
          state_d = teq_pkg::S_TK_END;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = teq_pkg::RD_CUR;
          state_d      = teq_pkg::S_TK_DEC;
        end
      end
      teq_pkg::S_TK_DEC: begin
        if (sts_i.pend_v) begin
          if (sts_i.out_free) begin
            cmd_o.emit      = 1'b1;
            cmd_o.emit_st   = teq_pkg::ST_FIRE;
            cmd_o.emit_last = !sts_i.due;
            if (sts_i.due) begin
              cmd_o.pop = 1'b1;
              state_d   = teq_pkg::S_TK_RD;
            end else begin
              state_d = teq_pkg::S_IDLE;
            end
          end
        end else if (sts_i.due) begin
          cmd_o.pop = 1'b1;
          state_d   = teq_pkg::S_TK_RD;
        end else if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_st   = teq_pkg::ST_NONE;
          cmd_o.emit_last = 1'b1;
          state_d         = teq_pkg::S_IDLE;
        end
      end
      teq_pkg::S_TK_END: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_st   = sts_i.pend_v ? teq_pkg::ST_FIRE : teq_pkg::ST_NONE;
          cmd_o.emit_last = 1'b1;
          state_d         = teq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = teq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[rtl/timed_event_queue_top.sv]
// Timed event queue. Holds up to teq_pkg::DEPTH fire events sorted by time in a
// circular table with one read and one write port (one write and one registered
// read per cycle). An add request (req_type 0) gives one result: added, duplicate
// (same slat and cue already stored, checked even when full) or table full. A tick
// request (req_type 1) gives one fire result per event whose time is at or before
// the tick time, oldest first, with last_of_run on the final one, or a single
// nothing-due result. The controller handles one request at a time; a result
// waiting in the output register does not block taking the next request. An add
// reads and compares every stored entry in turn, then, unless rejected, moves each
// later entry up one slot and writes the new one, using the single read port once
// per compare and once per moved entry. A tick reads each head entry before it is
// checked.
module timed_event_queue_top (
  input logic      clk_i,
  input logic      rst_ni,
  teq_in_if.sink   req_i,
  teq_out_if.source rsp_o
);

  teq_pkg::cmd_t cmd;
  teq_pkg::sts_t sts;

  teq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  teq_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_type_i   (req_i.req_type),
    .event_time_i (req_i.event_time),
    .slat_id_i    (req_i.slat_id),
    .cue_id_i     (req_i.cue_id),
    .out_ready_i  (rsp_o.ready),
    .out_valid_o  (rsp_o.valid),
    .status_o     (rsp_o.status),
    .fire_slat_o  (rsp_o.fire_slat),
    .fire_cue_o   (rsp_o.fire_cue),
    .fire_time_o  (rsp_o.fire_time),
    .last_o       (rsp_o.last_of_run)
  );

endmodule
